/* hw/rtl/erg_pkg.sv */
// Shared types, constants and a helper function for the Euclidean rhythm generator.
package erg_pkg;

	localparam int CNT_W         = 7;
	localparam int PAT_W         = 64;
	localparam int MAX_STEPS_DEF = 64;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [PAT_W-1:0] pat_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic merge;
		logic place_a;
		logic place_b;
		logic commit;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic cb_le1;
		logic ca_zero;
		logic cb_zero;
	} status_t;

	// Word with the low n bits set.
	function automatic pat_t low_ones(input cnt_t n);
		pat_t r;
		if (n >= cnt_t'(PAT_W)) begin
			r = '1;
		end else begin
			r = (pat_t'(1) << n) - pat_t'(1);
		end
		return r;
	endfunction

endpackage

/* hw/rtl/erg_req_if.sv */
// Request channel: hit count and step count.
interface erg_req_if;
	logic                valid;
	logic                ready;
	logic [erg_pkg::CNT_W-1:0] hits;
	logic [erg_pkg::CNT_W-1:0] steps;

	modport source(output valid, hits, steps, input ready);
	modport sink(input valid, hits, steps, output ready);
endinterface

/* hw/rtl/erg_rsp_if.sv */
// Response channel: onset pattern and its length.
interface erg_rsp_if;
	logic                valid;
	logic                ready;
	logic [erg_pkg::PAT_W-1:0] pattern;
	logic [erg_pkg::CNT_W-1:0] length;

	modport source(output valid, pattern, length, input ready);
	modport sink(input valid, pattern, length, output ready);
endinterface

/* hw/rtl/erg_ctrl.sv */
// Sequencing state machine for the Euclidean rhythm generator.
module erg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic             rsp_ready,
	output logic             rsp_valid,
	input  erg_pkg::status_t status,
	output erg_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MERGE,
		S_PLACE_A,
		S_PLACE_B,
		S_DONE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:    cmd.load    = req_valid;
			S_MERGE:   cmd.merge   = !status.cb_le1;
			S_PLACE_A: cmd.place_a = !status.ca_zero;
			S_PLACE_B: cmd.place_b = !status.cb_zero;
			S_DONE:    cmd.commit  = !rsp_valid_q || rsp_ready;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:    if (req_valid) state_q <= S_MERGE;
				S_MERGE:   if (status.cb_le1) state_q <= S_PLACE_A;
				S_PLACE_A: if (status.ca_zero) state_q <= S_PLACE_B;
				S_PLACE_B: if (status.cb_zero) state_q <= S_DONE;
				S_DONE:    if (cmd.commit) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/erg_datapath.sv */
// Group registers, merge step, pattern assembly and result register.
module erg_datapath #(
	parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
	input  logic             clk,
	input  erg_pkg::cnt_t    hits,
	input  erg_pkg::cnt_t    steps,
	input  erg_pkg::cmd_t    cmd,
	output erg_pkg::status_t status,
	output erg_pkg::pat_t    pattern,
	output erg_pkg::cnt_t    length
);

	localparam erg_pkg::cnt_t MaxSteps = erg_pkg::cnt_t'(MAX_STEPS);

	erg_pkg::pat_t pa_q, pb_q, word_q, pattern_q;
	erg_pkg::cnt_t la_q, lb_q, ca_q, cb_q, pos_q, n_q, length_q;

	erg_pkg::cnt_t n_sat;
	logic          special;
	erg_pkg::cnt_t m;
	erg_pkg::pat_t grp;
	erg_pkg::cnt_t grp_len;

	assign n_sat   = (steps > MaxSteps) ? MaxSteps : steps;
	assign special = (hits >= n_sat) || (hits == '0);
	assign m       = (ca_q < cb_q) ? ca_q : cb_q;
	assign grp     = cmd.place_a ? pa_q : pb_q;
	assign grp_len = cmd.place_a ? la_q : lb_q;

	assign status.cb_le1  = (cb_q <= erg_pkg::cnt_t'(1));
	assign status.ca_zero = (ca_q == '0);
	assign status.cb_zero = (cb_q == '0);

	assign pattern = pattern_q;
	assign length  = length_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= n_sat;
			pa_q   <= erg_pkg::pat_t'(1);
			pb_q   <= '0;
			la_q   <= erg_pkg::cnt_t'(1);
			lb_q   <= erg_pkg::cnt_t'(1);
			pos_q  <= '0;
			if (special) begin
				// Degenerate cases skip merging and placement entirely.
				ca_q   <= '0;
				cb_q   <= '0;
				word_q <= (hits >= n_sat) ? erg_pkg::low_ones(n_sat) : '0;
			end else begin
				ca_q   <= hits;
				cb_q   <= n_sat - hits;
				word_q <= '0;
			end
		end else if (cmd.merge) begin
			pa_q <= pa_q | ((la_q < erg_pkg::cnt_t'(erg_pkg::PAT_W)) ? (pb_q << la_q) : '0);
			la_q <= la_q + lb_q;
			ca_q <= m;
			if (ca_q > cb_q) begin
				// Leftover A groups become the new B groups.
				pb_q <= pa_q;
				lb_q <= la_q;
				cb_q <= ca_q - m;
			end else begin
				cb_q <= cb_q - m;
			end
		end else if (cmd.place_a || cmd.place_b) begin
			if (pos_q < erg_pkg::cnt_t'(erg_pkg::PAT_W)) begin
				word_q <= word_q | (grp << pos_q);
			end
			pos_q <= pos_q + grp_len;
			if (cmd.place_a) begin
				ca_q <= ca_q - erg_pkg::cnt_t'(1);
			end else begin
				cb_q <= cb_q - erg_pkg::cnt_t'(1);
			end
		end
		if (cmd.commit) begin
			pattern_q <= word_q & erg_pkg::low_ones(n_q);
			length_q  <= n_q;
		end
	end

endmodule

/* hw/rtl/euclidean_rhythm_generator.sv */
// Top level of the Euclidean rhythm generator: controller plus datapath.
//
// Each request transaction carries a hit count and a step count and yields one
// response transaction holding the Euclidean onset pattern (bit i is step i,
// bits at or above the length are zero) and its length. Step counts above
// MAX_STEPS saturate to MAX_STEPS, and the reported length is the saturated
// value. The pattern is built by Bjorklund group merging: one merge round per
// cycle, then one cycle per resulting group to lay the groups into the output
// word. Let R be the number of merge rounds and G the number of groups left
// after merging. Every merge round removes at least one group, so R + G never
// exceeds the saturated step count; it reaches 64 at 64 steps, for example with
// a single hit (62 rounds) or with one hit fewer than the steps (64 groups to
// place). Zero steps, zero hits and hits at or above steps skip both loops.
// One item is processed at a time; a finished response sits in an output
// register, and the controller is ready for the next request transaction once
// the response is registered, while the response still waits.
module euclidean_rhythm_generator #(
	parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	erg_req_if.sink  req,
	erg_rsp_if.source rsp
);

	erg_pkg::cmd_t    cmd;
	erg_pkg::status_t status;

	// The controller sequences load, merge rounds, placement and the hand-off
	// to the response register; it owns the response valid flag.
	erg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the two group patterns, their lengths and counts,
	// the assembly word and the response payload register.
	erg_datapath #(
		.MAX_STEPS (MAX_STEPS)
	) u_datapath (
		.clk     (clk),
		.hits    (req.hits),
		.steps   (req.steps),
		.cmd     (cmd),
		.status  (status),
		.pattern (rsp.pattern),
		.length  (rsp.length)
	);

endmodule
